// ----- design/scc_pkg.sv -----
// Shared types and codes for the strongly connected components engine.
`timescale 1ns / 1ps

package scc_pkg;

  localparam int NAME_W = 32;
  localparam int COMP_W = 7;

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_DEL    = 2'd1;
  localparam logic [1:0] REQ_SEARCH = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [NAME_W-1:0] src_name;
    logic [NAME_W-1:0] dst_name;
  } in_item_t;

  typedef struct packed {
    logic [NAME_W-1:0] vertex_name;
    logic [COMP_W-1:0] component;
    logic [1:0]        status;
    logic              last;
  } out_item_t;

endpackage

// ----- design/strongly_connected_components.sv -----
// Directed graph engine: edge updates and Tarjan component search over a shared sequencer.
//
//  channel | direction | handshake          | beat contents
//  in_     | input     | in_valid / in_stall   | req_type, src_name, dst_name
//  out_    | output    | out_valid / out_stall | vertex_name, component, status, last
//
// An edge request scans the name table one entry a cycle for the n known vertices.
// A search steps one neighbour column per cycle for every vertex, held for an extra
// state on each edge to a vertex still pending and on each vertex entered, and then
// emits one result per vertex through S_ERD and S_EOUT, held while the output stalls.
// Reset clears the vertex count, the adjacency row valid bits and the sequencer.
// A new request is taken only in the idle state; a stalled result holds the output register.
`timescale 1ns / 1ps

module strongly_connected_components #(
  parameter int MAX_VERTS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  scc_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output scc_pkg::out_item_t  out_data
);
  import scc_pkg::*;

  localparam int IW = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
  localparam int CW = $clog2(MAX_VERTS + 1);

  typedef struct packed {
    logic [IW-1:0] v;
    logic [CW-1:0] nxt;
  } walk_t;

  typedef enum logic [17:0] {
    S_IDLE   = 18'b000000000000000001,
    S_LOOK   = 18'b000000000000000010,
    S_DECIDE = 18'b000000000000000100,
    S_WSRC   = 18'b000000000000001000,
    S_WDST   = 18'b000000000000010000,
    S_AWR    = 18'b000000000000100000,
    S_RESP   = 18'b000000000001000000,
    S_ROOT   = 18'b000000000010000000,
    S_ROW    = 18'b000000000100000000,
    S_SCAN   = 18'b000000001000000000,
    S_CMP    = 18'b000000010000000000,
    S_PRD    = 18'b000000100000000000,
    S_PPOP   = 18'b000001000000000000,
    S_RW     = 18'b000010000000000000,
    S_RL     = 18'b000100000000000000,
    S_RD     = 18'b001000000000000000,
    S_ERD    = 18'b010000000000000000,
    S_EOUT   = 18'b100000000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [1:0]           req_r, req_nxt;
  logic [NAME_W-1:0]    src_r, src_nxt, dst_r, dst_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        scan_r, scan_nxt;
  logic                 cmpv_r, cmpv_nxt;
  logic [IW-1:0]        cmp_idx_r, cmp_idx_nxt;
  logic                 a_found_r, a_found_nxt, b_found_r, b_found_nxt;
  logic [IW-1:0]        a_id_r, a_id_nxt, b_id_r, b_id_nxt;
  logic [1:0]           status_r, status_nxt;
  logic [MAX_VERTS-1:0] visited_r, visited_nxt, finished_r, finished_nxt;
  logic [MAX_VERTS-1:0] row_valid_r, row_valid_nxt;
  logic [MAX_VERTS-1:0] row_r, row_nxt;
  logic [CW-1:0]        wdepth_r, wdepth_nxt, pdepth_r, pdepth_nxt;
  logic [CW-1:0]        clock_r, clock_nxt, comp_r, comp_nxt, root_r, root_nxt;
  logic [IW-1:0]        top_v_r, top_v_nxt;
  logic [CW-1:0]        top_i_r, top_i_nxt, top_low_r, top_low_nxt, top_ord_r, top_ord_nxt;
  logic [CW-1:0]        child_low_r, child_low_nxt;
  logic                 upd_r, upd_nxt;
  logic [CW-1:0]        k_r, k_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  // Memories with registered read data.
  logic [NAME_W-1:0]    name_mem [MAX_VERTS];
  logic [MAX_VERTS-1:0] adj_mem  [MAX_VERTS];
  logic [CW-1:0]        ord_mem  [MAX_VERTS];
  logic [CW-1:0]        low_mem  [MAX_VERTS];
  logic [CW-1:0]        comp_mem [MAX_VERTS];
  logic [IW-1:0]        pend_mem [MAX_VERTS];
  walk_t                walk_mem [MAX_VERTS];

  logic                 name_we, adj_we, ord_we, low_we, comp_we, pend_we, walk_we;
  logic [IW-1:0]        name_wa, adj_wa, ord_wa, low_wa, comp_wa, pend_wa, walk_wa;
  logic [IW-1:0]        name_ra, adj_ra, ord_ra, low_ra, comp_ra, pend_ra, walk_ra;
  logic [NAME_W-1:0]    name_wd, name_q;
  logic [MAX_VERTS-1:0] adj_wd, adj_q;
  logic                 aval_q;
  logic [CW-1:0]        ord_wd, ord_q, low_wd, low_q, comp_wd, comp_q;
  logic [IW-1:0]        pend_wd, pend_q;
  walk_t                walk_wd, walk_q;

  logic                 in_acc, out_free, do_enter;
  logic [IW-1:0]        enter_w, ti;
  logic [CW-1:0]        clock_inc;
  logic [1:0]           need;
  logic [MAX_VERTS-1:0] new_row;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign clock_inc = clock_r + CW'(1);
  assign ti        = top_i_r[IW-1:0];

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    count_nxt     = count_r;
    scan_nxt      = scan_r;
    cmpv_nxt      = cmpv_r;
    cmp_idx_nxt   = cmp_idx_r;
    a_found_nxt   = a_found_r;
    b_found_nxt   = b_found_r;
    a_id_nxt      = a_id_r;
    b_id_nxt      = b_id_r;
    status_nxt    = status_r;
    visited_nxt   = visited_r;
    finished_nxt  = finished_r;
    row_valid_nxt = row_valid_r;
    row_nxt       = row_r;
    wdepth_nxt    = wdepth_r;
    pdepth_nxt    = pdepth_r;
    clock_nxt     = clock_r;
    comp_nxt      = comp_r;
    root_nxt      = root_r;
    top_v_nxt     = top_v_r;
    top_i_nxt     = top_i_r;
    top_low_nxt   = top_low_r;
    top_ord_nxt   = top_ord_r;
    child_low_nxt = child_low_r;
    upd_nxt       = upd_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    name_we = 1'b0; name_wa = '0; name_wd = '0; name_ra = '0;
    adj_we  = 1'b0; adj_wa  = '0; adj_wd  = '0; adj_ra  = '0;
    ord_we  = 1'b0; ord_wa  = '0; ord_wd  = '0; ord_ra  = '0;
    low_we  = 1'b0; low_wa  = '0; low_wd  = '0; low_ra  = '0;
    comp_we = 1'b0; comp_wa = '0; comp_wd = '0; comp_ra = '0;
    pend_we = 1'b0; pend_wa = '0; pend_wd = '0; pend_ra = '0;
    walk_we = 1'b0; walk_wa = '0; walk_wd = '0; walk_ra = '0;
    do_enter = 1'b0;
    enter_w  = '0;
    need     = 2'd0;
    new_row  = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          req_nxt = in_data.req_type;
          src_nxt = in_data.src_name;
          dst_nxt = in_data.dst_name;
          unique case (in_data.req_type)
            REQ_ADD, REQ_DEL: begin
              scan_nxt    = '0;
              cmpv_nxt    = 1'b0;
              a_found_nxt = 1'b0;
              b_found_nxt = 1'b0;
              state_nxt   = S_LOOK;
            end
            REQ_SEARCH: begin
              if (count_r == '0) begin
                status_nxt = STAT_EMPTY;
                state_nxt  = S_RESP;
              end else begin
                visited_nxt  = '0;
                finished_nxt = '0;
                wdepth_nxt   = '0;
                pdepth_nxt   = '0;
                clock_nxt    = '0;
                comp_nxt     = '0;
                root_nxt     = '0;
                state_nxt    = S_ROOT;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_LOOK: begin
        if (cmpv_r) begin
          if (!a_found_r && name_q == src_r) begin
            a_found_nxt = 1'b1;
            a_id_nxt    = cmp_idx_r;
          end
          if (!b_found_r && name_q == dst_r) begin
            b_found_nxt = 1'b1;
            b_id_nxt    = cmp_idx_r;
          end
        end
        if (scan_r < count_r) begin
          name_ra     = scan_r[IW-1:0];
          cmp_idx_nxt = scan_r[IW-1:0];
          cmpv_nxt    = 1'b1;
          scan_nxt    = scan_r + CW'(1);
        end else begin
          cmpv_nxt = 1'b0;
          if (!cmpv_r) begin
            state_nxt = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        // A new name used as both ends of the edge needs only one entry.
        need = {1'b0, !a_found_r}
             + {1'b0, !b_found_r && !(!a_found_r && src_r == dst_r)};
        if (({1'b0, count_r} + (CW+1)'(need)) > (CW+1)'(MAX_VERTS)) begin
          status_nxt = STAT_FULL;
          state_nxt  = S_RESP;
        end else begin
          state_nxt = S_WSRC;
        end
      end
      S_WSRC: begin
        if (!a_found_r) begin
          name_we     = 1'b1;
          name_wa     = count_r[IW-1:0];
          name_wd     = src_r;
          a_id_nxt    = count_r[IW-1:0];
          a_found_nxt = 1'b1;
          count_nxt   = count_r + CW'(1);
          if (src_r == dst_r) begin
            b_id_nxt    = count_r[IW-1:0];
            b_found_nxt = 1'b1;
          end
        end
        state_nxt = S_WDST;
      end
      S_WDST: begin
        if (!b_found_r) begin
          name_we   = 1'b1;
          name_wa   = count_r[IW-1:0];
          name_wd   = dst_r;
          b_id_nxt  = count_r[IW-1:0];
          count_nxt = count_r + CW'(1);
        end
        adj_ra    = a_id_r;
        state_nxt = S_AWR;
      end
      S_AWR: begin
        new_row         = aval_q ? adj_q : '0;
        new_row[b_id_r] = (req_r == REQ_ADD);
        adj_we          = 1'b1;
        adj_wa          = a_id_r;
        adj_wd          = new_row;
        row_valid_nxt[a_id_r] = 1'b1;
        status_nxt      = STAT_OK;
        state_nxt       = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.vertex_name = '0;
          out_data_nxt.component   = '0;
          out_data_nxt.status      = status_r;
          out_data_nxt.last        = 1'b1;
          state_nxt                = S_IDLE;
        end
      end
      S_ROOT: begin
        if (root_r == count_r) begin
          k_nxt     = '0;
          state_nxt = S_ERD;
        end else if (visited_r[root_r[IW-1:0]]) begin
          root_nxt = root_r + CW'(1);
        end else begin
          do_enter = 1'b1;
          enter_w  = root_r[IW-1:0];
        end
      end
      S_ROW: begin
        row_nxt   = aval_q ? adj_q : '0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (top_i_r < count_r) begin
          top_i_nxt = top_i_r + CW'(1);
          if (row_r[ti]) begin
            if (!visited_r[ti]) begin
              do_enter = 1'b1;
              enter_w  = ti;
            end else if (!finished_r[ti]) begin
              ord_ra    = ti;
              state_nxt = S_CMP;
            end
          end
        end else begin
          // All neighbours done: retire the vertex on top of the walk.
          wdepth_nxt    = wdepth_r - CW'(1);
          child_low_nxt = top_low_r;
          if (top_low_r == top_ord_r) begin
            comp_nxt  = comp_r + CW'(1);
            upd_nxt   = 1'b0;
            state_nxt = S_PRD;
          end else begin
            upd_nxt   = 1'b1;
            state_nxt = (wdepth_r > CW'(1)) ? S_RW : S_ROOT;
          end
        end
      end
      S_CMP: begin
        if (ord_q < top_low_r) begin
          top_low_nxt = ord_q;
        end
        state_nxt = S_SCAN;
      end
      S_PRD: begin
        pend_ra   = pdepth_nxt[IW-1:0] - IW'(1);
        state_nxt = S_PPOP;
      end
      S_PPOP: begin
        finished_nxt[pend_q] = 1'b1;
        comp_we    = 1'b1;
        comp_wa    = pend_q;
        comp_wd    = comp_r;
        pdepth_nxt = pdepth_r - CW'(1);
        if (pend_q == top_v_r || pdepth_r == CW'(1)) begin
          state_nxt = (wdepth_r != '0) ? S_RW : S_ROOT;
        end else begin
          state_nxt = S_PRD;
        end
      end
      S_RW: begin
        walk_ra   = wdepth_r[IW-1:0] - IW'(1);
        state_nxt = S_RL;
      end
      S_RL: begin
        top_v_nxt = walk_q.v;
        top_i_nxt = walk_q.nxt;
        low_ra    = walk_q.v;
        ord_ra    = walk_q.v;
        adj_ra    = walk_q.v;
        state_nxt = S_RD;
      end
      S_RD: begin
        top_low_nxt = (upd_r && child_low_r < low_q) ? child_low_r : low_q;
        top_ord_nxt = ord_q;
        row_nxt     = aval_q ? adj_q : '0;
        state_nxt   = S_SCAN;
      end
      S_ERD: begin
        name_ra   = k_r[IW-1:0];
        comp_ra   = k_r[IW-1:0];
        state_nxt = S_EOUT;
      end
      S_EOUT: begin
        // Keep the read address so the registered data holds while the output waits.
        name_ra = k_r[IW-1:0];
        comp_ra = k_r[IW-1:0];
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.vertex_name = name_q;
          out_data_nxt.component   = COMP_W'(comp_q);
          out_data_nxt.status      = STAT_OK;
          out_data_nxt.last        = ((k_r + CW'(1)) == count_r);
          if ((k_r + CW'(1)) == count_r) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + CW'(1);
            state_nxt = S_ERD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Entering a vertex stamps it, pushes it on both stacks and saves the old top.
    if (do_enter) begin
      clock_nxt            = clock_inc;
      ord_we               = 1'b1;
      ord_wa               = enter_w;
      ord_wd               = clock_inc;
      visited_nxt[enter_w] = 1'b1;
      pend_we              = 1'b1;
      pend_wa              = pdepth_r[IW-1:0];
      pend_wd              = enter_w;
      pdepth_nxt           = pdepth_r + CW'(1);
      if (wdepth_r != '0) begin
        walk_we     = 1'b1;
        walk_wa     = wdepth_r[IW-1:0] - IW'(1);
        walk_wd.v   = top_v_r;
        walk_wd.nxt = top_i_nxt;
        low_we      = 1'b1;
        low_wa      = top_v_r;
        low_wd      = top_low_r;
      end
      wdepth_nxt  = wdepth_r + CW'(1);
      top_v_nxt   = enter_w;
      top_i_nxt   = '0;
      top_low_nxt = clock_inc;
      top_ord_nxt = clock_inc;
      adj_ra      = enter_w;
      state_nxt   = S_ROW;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      row_valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      row_valid_r <= row_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    src_r       <= src_nxt;
    dst_r       <= dst_nxt;
    scan_r      <= scan_nxt;
    cmpv_r      <= cmpv_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    a_found_r   <= a_found_nxt;
    b_found_r   <= b_found_nxt;
    a_id_r      <= a_id_nxt;
    b_id_r      <= b_id_nxt;
    status_r    <= status_nxt;
    visited_r   <= visited_nxt;
    finished_r  <= finished_nxt;
    row_r       <= row_nxt;
    wdepth_r    <= wdepth_nxt;
    pdepth_r    <= pdepth_nxt;
    clock_r     <= clock_nxt;
    comp_r      <= comp_nxt;
    root_r      <= root_nxt;
    top_v_r     <= top_v_nxt;
    top_i_r     <= top_i_nxt;
    top_low_r   <= top_low_nxt;
    top_ord_r   <= top_ord_nxt;
    child_low_r <= child_low_nxt;
    upd_r       <= upd_nxt;
    k_r         <= k_nxt;
    out_data_r  <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (name_we) begin
      name_mem[name_wa] <= name_wd;
    end
    name_q <= name_mem[name_ra];
  end

  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[adj_wa] <= adj_wd;
    end
    adj_q  <= adj_mem[adj_ra];
    aval_q <= row_valid_r[adj_ra];
  end

  always_ff @(posedge clk) begin
    if (ord_we) begin
      ord_mem[ord_wa] <= ord_wd;
    end
    ord_q <= ord_mem[ord_ra];
  end

  always_ff @(posedge clk) begin
    if (low_we) begin
      low_mem[low_wa] <= low_wd;
    end
    low_q <= low_mem[low_ra];
  end

  always_ff @(posedge clk) begin
    if (comp_we) begin
      comp_mem[comp_wa] <= comp_wd;
    end
    comp_q <= comp_mem[comp_ra];
  end

  always_ff @(posedge clk) begin
    if (pend_we) begin
      pend_mem[pend_wa] <= pend_wd;
    end
    pend_q <= pend_mem[pend_ra];
  end

  always_ff @(posedge clk) begin
    if (walk_we) begin
      walk_mem[walk_wa] <= walk_wd;
    end
    walk_q <= walk_mem[walk_ra];
  end

endmodule

// ----- test/strongly_connected_components_tb.sv -----
// Self-checking testbench for the strongly connected components engine.
`timescale 1ns / 1ps

module strongly_connected_components_tb;
  import scc_pkg::*;

  localparam int NV = 64;
  localparam int CYCLE_LIMIT = 1500000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  strongly_connected_components #(.MAX_VERTS(NV)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Graph model and queue of results still owed by the block.
  class graph_scoreboard;
    logic [31:0]   names [NV];
    int            nverts;
    bit [NV-1:0]   adj [NV];
    out_item_t     owed [$];
    int            errors;

    function new();
      nverts = 0;
      errors = 0;
      foreach (adj[i]) adj[i] = '0;
    endfunction

    function int lookup(logic [31:0] nm);
      for (int i = 0; i < nverts; i++)
        if (names[i] == nm) return i;
      return -1;
    endfunction

    function void push_result(logic [31:0] nm, int comp, logic [1:0] st, bit lst);
      out_item_t r;
      r.vertex_name = nm;
      r.component = comp[6:0];
      r.status = st;
      r.last = lst;
      owed = {owed, r};
    endfunction

    function void label_components(ref int comp_of [NV]);
      int order [NV];
      int low [NV];
      bit done [NV];
      int wv [NV];
      int wn [NV];
      int pend [NV];
      int wd, pd, tick, comp, v, i, k, p;
      wd = 0; pd = 0; tick = 0; comp = 0;
      for (int j = 0; j < NV; j++) begin
        order[j] = 0; low[j] = 0; done[j] = 0;
      end
      for (int r = 0; r < nverts; r++) begin
        if (order[r] != 0) continue;
        tick++; order[r] = tick; low[r] = tick;
        pend[pd++] = r; wv[wd] = r; wn[wd] = 0; wd++;
        while (wd > 0) begin
          v = wv[wd-1];
          i = wn[wd-1];
          if (i < nverts) begin
            wn[wd-1] = i + 1;
            if (adj[v][i]) begin
              if (order[i] == 0) begin
                tick++; order[i] = tick; low[i] = tick;
                pend[pd++] = i; wv[wd] = i; wn[wd] = 0; wd++;
              end else if (!done[i] && order[i] < low[v]) begin
                low[v] = order[i];
              end
            end
          end else begin
            wd--;
            if (low[v] == order[v]) begin
              comp++;
              while (pd > 0) begin
                pd--;
                k = pend[pd];
                done[k] = 1;
                comp_of[k] = comp;
                if (k == v) break;
              end
            end else if (wd > 0) begin
              p = wv[wd-1];
              if (low[v] < low[p]) low[p] = low[v];
            end
          end
        end
      end
    endfunction

    function void note_request(in_item_t it);
      int a, b, need;
      int comp_of [NV];
      if (it.req_type == REQ_ADD || it.req_type == REQ_DEL) begin
        a = lookup(it.src_name);
        b = lookup(it.dst_name);
        need = 0;
        if (a < 0) need++;
        if (b < 0 && !(a < 0 && it.src_name == it.dst_name)) need++;
        if (nverts + need > NV) begin
          push_result('0, 0, STAT_FULL, 1'b1);
          return;
        end
        if (a < 0) begin
          names[nverts] = it.src_name; a = nverts; nverts++;
        end
        if (b < 0) begin
          b = lookup(it.dst_name);
          if (b < 0) begin
            names[nverts] = it.dst_name; b = nverts; nverts++;
          end
        end
        adj[a][b] = (it.req_type == REQ_ADD);
        push_result('0, 0, STAT_OK, 1'b1);
      end else if (it.req_type == REQ_SEARCH) begin
        if (nverts == 0) begin
          push_result('0, 0, STAT_EMPTY, 1'b1);
          return;
        end
        label_components(comp_of);
        for (int j = 0; j < nverts; j++)
          push_result(names[j], comp_of[j], STAT_OK, j == nverts - 1);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp_r = owed.pop_front();
      if (got.vertex_name !== exp_r.vertex_name)
        $display("%0t: vertex_name expected %h got %h", $time, exp_r.vertex_name,
                 got.vertex_name);
      if (got.component !== exp_r.component)
        $display("%0t: component expected %0d got %0d", $time, exp_r.component,
                 got.component);
      if (got.status !== exp_r.status)
        $display("%0t: status expected %0d got %0d", $time, exp_r.status, got.status);
      if (got.last !== exp_r.last)
        $display("%0t: last expected %0d got %0d", $time, exp_r.last, got.last);
      if (got !== exp_r) errors++;
    endfunction
  endclass

  graph_scoreboard board = new();
  logic [31:0] name_pool [16];
  int burst_left = 0;

  // Sends one beat; bursts of back-to-back beats are broken by random gaps.
  task send_beat(logic [1:0] rq, logic [31:0] s, logic [31:0] d);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
    burst_left--;
    in_data.req_type = rq;
    in_data.src_name = s;
    in_data.dst_name = d;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    board.note_request(in_data);
    @(negedge clk);
    if (burst_left == 0) in_valid = 1'b0;
  endtask

  task go_idle();
    in_valid = 1'b0;
    burst_left = 0;
    while (board.owed.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task send_random_edge(int pool_size);
    logic [1:0] rq;
    rq = ($urandom_range(0, 3) == 0) ? REQ_DEL : REQ_ADD;
    send_beat(rq, name_pool[$urandom_range(0, pool_size - 1)],
              name_pool[$urandom_range(0, pool_size - 1)]);
  endtask

  // Receiver stall pattern: alternating quiet and busy stretches.
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase % 200 < 60) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk)
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);

  int cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("strongly_connected_components test failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part.
    send_beat(REQ_SEARCH, 32'h0, 32'h0);
    send_beat(REQ_ADD, 32'hFFFF_FFFF, 32'h0000_0000);
    send_beat(REQ_ADD, 32'h0000_0000, 32'hFFFF_FFFF);
    send_beat(REQ_ADD, 32'h5555_5555, 32'h5555_5555);
    send_beat(REQ_ADD, 32'hAAAA_AAAA, 32'h5555_5555);
    send_beat(REQ_ADD, 32'hAAAA_AAAA, 32'h5555_5555);
    send_beat(REQ_DEL, 32'h1234_5678, 32'hFFFF_FFFF);
    send_beat(REQ_DEL, 32'h1234_5678, 32'hFFFF_FFFF);
    send_beat(2'd3, 32'hDEAD_BEEF, 32'h0);
    send_beat(REQ_SEARCH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(REQ_DEL, 32'h0000_0000, 32'hFFFF_FFFF);
    send_beat(REQ_SEARCH, 32'h0, 32'h0);
    go_idle();

    // Random graphs over a small name pool.
    for (int i = 0; i < 16; i++) name_pool[i] = $urandom;
    for (int g = 0; g < 150; g++) begin
      if (g % 10 == 9) send_beat(REQ_SEARCH, $urandom, $urandom);
      else if ($urandom_range(0, 30) == 0) send_beat(2'd3, $urandom, $urandom);
      else send_random_edge(16);
    end
    send_beat(REQ_SEARCH, 32'h0, 32'h0);
    go_idle();

    // Fill the name table to its limit, then push past it.
    for (int i = 0; i < 30; i++) send_beat(REQ_ADD, $urandom, $urandom);
    send_beat(REQ_ADD, 32'hCAFE_0001, 32'hCAFE_0001);
    send_beat(REQ_ADD, $urandom, $urandom);
    send_beat(REQ_ADD, 32'hCAFE_0001, $urandom);
    send_beat(REQ_DEL, $urandom, $urandom);
    for (int i = 0; i < 8; i++) send_random_edge(16);
    send_beat(REQ_SEARCH, 32'h0, 32'h0);
    go_idle();

    if (board.errors == 0 && board.owed.size() == 0)
      $display("strongly_connected_components test passed");
    else
      $display("strongly_connected_components test failed");
    $finish;
  end

endmodule
